### rtl/djrq_pkg.sv
// Shared constants, codes and types of the deduplicating job ring queue.
`default_nettype none
package djrq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int OP_W = 2;
  localparam int KEY_W = 64;
  localparam int PAY_W = 32;
  localparam int ST_W = 3;
  localparam int OCC_W = 5;

  localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

  localparam logic [ST_W-1:0] ST_ADDED = 3'd0;
  localparam logic [ST_W-1:0] ST_REPLACED = 3'd1;
  localparam logic [ST_W-1:0] ST_IGNORED = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL = 3'd3;
  localparam logic [ST_W-1:0] ST_TAKEN = 3'd4;
  localparam logic [ST_W-1:0] ST_EMPTY = 3'd5;
  localparam logic [ST_W-1:0] ST_RELEASED = 3'd6;
  localparam logic [ST_W-1:0] ST_REL_ERROR = 3'd7;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
    logic             kind;
    logic             in_prog;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage
`default_nettype wire

### rtl/djrq_if.sv
// Request and response channel interfaces of the job ring queue.
`default_nettype none
interface djrq_req_if;
  import djrq_pkg::*;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [KEY_W-1:0] job_key;
  logic [PAY_W-1:0] job_payload;
  logic             job_kind;
  modport source(output valid, output opcode, output job_key, output job_payload,
                 output job_kind, input ready);
  modport sink(input valid, input opcode, input job_key, input job_payload,
               input job_kind, output ready);
endinterface

interface djrq_rsp_if;
  import djrq_pkg::*;
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [KEY_W-1:0] out_key;
  logic [PAY_W-1:0] out_payload;
  logic             out_kind;
  logic [OCC_W-1:0] occupancy;
  modport source(output valid, output status, output out_key, output out_payload,
                 output out_kind, output occupancy, input ready);
  modport sink(input valid, input status, input out_key, input out_payload,
               input out_kind, input occupancy, output ready);
endinterface
`default_nettype wire

### rtl/djrq_cell.sv
// One queue cell: holds one entry and takes its neighbor's entry on a shift.
`default_nettype none
module djrq_cell (
  input  wire logic                clk,
  input  wire djrq_pkg::cell_ctrl_t ctl,
  input  wire djrq_pkg::entry_t    load_data,
  input  wire djrq_pkg::entry_t    nbr,
  output djrq_pkg::entry_t         ent
);
  import djrq_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      ent <= load_data;
    end else if (ctl.shift) begin
      ent <= nbr;
    end
  end

endmodule
`default_nettype wire

### rtl/dedup_job_ring_queue.sv
// Top level of the deduplicating job ring queue built as a rotating row of cells.
//
//   Channel  Direction  Handshake      Carries
//   req      in         valid/ready    opcode, job_key, job_payload, job_kind
//   rsp      out        valid/ready    status, out_key, out_payload, out_kind, occupancy
//
// Cell 0 always holds the head; while an enqueue scans or a release executes, the cells
// rotate toward cell 0 one step a cycle. An enqueue makes one full rotation of the ring past
// the single key comparator at cell 0. Dequeue, release and no-op pass through S_EXEC.
// Reset (synchronous) empties the queue; cell contents are not cleared.
// A new transaction is taken while the previous response still waits on rsp;
// the block stalls only when a finished result finds the output register full.
`default_nettype none
module dedup_job_ring_queue (
  input wire logic   clk,
  input wire logic   rst,
  djrq_req_if.sink   req,
  djrq_rsp_if.source rsp
);
  import djrq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]       state;
  logic [OP_W-1:0]  op;
  logic [KEY_W-1:0] rkey;
  logic [PAY_W-1:0] rpay;
  logic             rkind;
  logic [IDX_W-1:0] idx;
  logic [CNT_W-1:0] count;
  logic             found;
  logic [ST_W-1:0]  res_status;
  logic [KEY_W-1:0] res_key;
  logic [PAY_W-1:0] res_pay;
  logic             res_kind;
  logic             ov;
  logic [ST_W-1:0]  o_status;
  logic [KEY_W-1:0] o_key;
  logic [PAY_W-1:0] o_pay;
  logic             o_kind;
  logic [OCC_W-1:0] o_occ;

  entry_t     ent [QUEUE_DEPTH];
  entry_t     head;
  entry_t     fb;
  entry_t     head_taken;
  logic       active;
  logic       hit;
  logic       append;
  logic       last_step;
  logic       empty;
  logic       out_load;
  cell_ctrl_t ctl0;
  cell_ctrl_t ctln;

  assign head = ent[0];
  assign empty = (count == '0);
  assign active = (CNT_W'(idx) < count);
  assign hit = (state == S_SCAN) && active && !found && (head.key == rkey);
  assign append = (state == S_SCAN) && !found && (CNT_W'(idx) == count);
  assign last_step = (idx == IDX_W'(QUEUE_DEPTH - 1));
  assign out_load = (state == S_DONE) && (!ov || rsp.ready);

  // The entry leaving cell 0 re-enters at the tail, edited on a replace or an append.
  always_comb begin
    fb = head;
    if (hit && !head.in_prog) begin
      fb.payload = rpay;
      fb.kind = rkind;
      fb.in_prog = 1'b0;
    end
    if (append) begin
      fb.key = rkey;
      fb.payload = rpay;
      fb.kind = rkind;
      fb.in_prog = 1'b0;
    end
  end

  always_comb begin
    head_taken = head;
    head_taken.in_prog = 1'b1;
    ctln.shift = (state == S_SCAN) ||
                 ((state == S_EXEC) && (op == OP_RELEASE) && !empty);
    ctln.load = 1'b0;
    ctl0.shift = ctln.shift;
    ctl0.load = (state == S_EXEC) && (op == OP_DEQUEUE) && !empty;
  end

  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    if (k == 0) begin : g_head
      djrq_cell u_cell (
        .clk      (clk),
        .ctl      (ctl0),
        .load_data(head_taken),
        .nbr      ((QUEUE_DEPTH > 1) ? ent[(k + 1) % QUEUE_DEPTH] : fb),
        .ent      (ent[k])
      );
    end else if (k == QUEUE_DEPTH - 1) begin : g_tail
      djrq_cell u_cell (
        .clk      (clk),
        .ctl      (ctln),
        .load_data(head_taken),
        .nbr      (fb),
        .ent      (ent[k])
      );
    end else begin : g_mid
      djrq_cell u_cell (
        .clk      (clk),
        .ctl      (ctln),
        .load_data(head_taken),
        .nbr      (ent[k + 1]),
        .ent      (ent[k])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      found <= 1'b0;
      idx <= '0;
      ov <= 1'b0;
    end else begin
      if (out_load) begin
        ov <= 1'b1;
      end else if (ov && rsp.ready) begin
        ov <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op <= req.opcode;
            rkey <= req.job_key;
            rpay <= req.job_payload;
            rkind <= req.job_kind;
            idx <= '0;
            found <= 1'b0;
            state <= (req.opcode == OP_ENQUEUE) ? S_SCAN : S_EXEC;
          end
        end
        S_EXEC: begin
          case (op)
            OP_DEQUEUE: begin
              if (!empty) begin
                res_status <= ST_TAKEN;
                res_key <= head.key;
                res_pay <= head.payload;
                res_kind <= head.kind;
              end else begin
                res_status <= ST_EMPTY;
                res_key <= '0;
                res_pay <= '0;
                res_kind <= 1'b0;
              end
            end
            OP_RELEASE: begin
              res_pay <= '0;
              res_kind <= 1'b0;
              if (empty) begin
                res_status <= ST_REL_ERROR;
                res_key <= '0;
              end else begin
                res_status <= ST_RELEASED;
                res_key <= head.key;
                count <= count - 1'b1;
              end
            end
            default: begin
              res_status <= ST_EMPTY;
              res_key <= '0;
              res_pay <= '0;
              res_kind <= 1'b0;
            end
          endcase
          state <= S_DONE;
        end
        S_SCAN: begin
          res_key <= rkey;
          res_pay <= '0;
          res_kind <= 1'b0;
          if (hit) begin
            found <= 1'b1;
            res_status <= head.in_prog ? ST_IGNORED : ST_REPLACED;
          end
          // Once appended, the slots behind the new entry must not take it again.
          if (append) begin
            found <= 1'b1;
            count <= count + 1'b1;
            res_status <= ST_ADDED;
          end
          if (last_step) begin
            if (!found && !hit && (count == CNT_W'(QUEUE_DEPTH))) begin
              res_status <= ST_FULL;
            end
            state <= S_DONE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_DONE: begin
          if (out_load) begin
            o_status <= res_status;
            o_key <= res_key;
            o_pay <= res_pay;
            o_kind <= res_kind;
            o_occ <= OCC_W'(count);
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = ov;
  assign rsp.status = o_status;
  assign rsp.out_key = o_key;
  assign rsp.out_payload = o_pay;
  assign rsp.out_kind = o_kind;
  assign rsp.occupancy = o_occ;

  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(QUEUE_DEPTH))
    else $error("Entry count exceeds the queue depth.");

  assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == S_SCAN || state == S_EXEC))
    else $error("Accepted transaction did not start work.");

  assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status == ST_ADDED || rsp.status == ST_TAKEN ||
                   rsp.status == ST_REPLACED)) |-> (rsp.occupancy != '0))
    else $error("Response reports an entry while the queue is empty.");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && hit) |=> found)
    else $error("Key match was not recorded.");

endmodule
`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for the deduplicating job ring queue.
`timescale 1ns / 100ps
module testbench;
  import djrq_pkg::*;

  localparam logic [OP_W-1:0] OP_NOP = 2'd3;
  localparam int RANDOM_ITEMS = 1525;
  localparam int CALM_AFTER = 1350;
  localparam int SQUEEZE_AFTER = 300;
  localparam int SQUEEZE_CYCLES = 400;
  localparam int KEY_POOL = 24;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
    logic             kind;
    logic [OCC_W-1:0] occupancy;
  } queue_answer_t;

  // Tracks the queue contents and holds the answers still owed by the block.
  class job_ring_tracker;
    entry_t        slots[QUEUE_DEPTH];
    int unsigned   head;
    int unsigned   count;
    queue_answer_t pending_answers[$];
    int unsigned   mismatches;

    function new();
      head = 0;
      count = 0;
      mismatches = 0;
    endfunction

    task report(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    function void note_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                               input logic [PAY_W-1:0] payload, input logic kind);
      queue_answer_t ans;
      int unsigned idx;
      bit hit;
      ans = '0;
      hit = 0;
      case (op)
        OP_ENQUEUE: begin
          ans.key = key;
          for (int i = 0; i < count && !hit; i++) begin
            idx = (head + i) % QUEUE_DEPTH;
            if (slots[idx].key == key) begin
              hit = 1;
              if (slots[idx].in_prog) begin
                ans.status = ST_IGNORED;
              end else begin
                slots[idx].payload = payload;
                slots[idx].kind = kind;
                ans.status = ST_REPLACED;
              end
            end
          end
          if (!hit) begin
            if (count >= QUEUE_DEPTH) begin
              ans.status = ST_FULL;
            end else begin
              idx = (head + count) % QUEUE_DEPTH;
              slots[idx].key = key;
              slots[idx].payload = payload;
              slots[idx].kind = kind;
              slots[idx].in_prog = 1'b0;
              count++;
              ans.status = ST_ADDED;
            end
          end
        end
        OP_DEQUEUE: begin
          if (count == 0) begin
            ans.status = ST_EMPTY;
          end else begin
            slots[head].in_prog = 1'b1;
            ans.status = ST_TAKEN;
            ans.key = slots[head].key;
            ans.payload = slots[head].payload;
            ans.kind = slots[head].kind;
          end
        end
        OP_RELEASE: begin
          if (count == 0) begin
            ans.status = ST_REL_ERROR;
          end else begin
            ans.status = ST_RELEASED;
            ans.key = slots[head].key;
            count--;
            head = (head + 1) % QUEUE_DEPTH;
          end
        end
        default: begin
          ans.status = ST_EMPTY;
        end
      endcase
      ans.occupancy = OCC_W'(count);
      pending_answers.push_back(ans);
    endfunction

    task check_answer(input logic [ST_W-1:0] status, input logic [KEY_W-1:0] key,
                      input logic [PAY_W-1:0] payload, input logic kind,
                      input logic [OCC_W-1:0] occupancy);
      queue_answer_t exp;
      if (pending_answers.size() == 0) begin
        report($sformatf("response with nothing outstanding, status %0d", status));
        return;
      end
      exp = pending_answers.pop_front();
      if (status !== exp.status)
        report($sformatf("status %0d, expected %0d", status, exp.status));
      if (key !== exp.key)
        report($sformatf("out_key %h, expected %h", key, exp.key));
      if (payload !== exp.payload)
        report($sformatf("out_payload %h, expected %h", payload, exp.payload));
      if (kind !== exp.kind)
        report($sformatf("out_kind %b, expected %b", kind, exp.kind));
      if (occupancy !== exp.occupancy)
        report($sformatf("occupancy %0d, expected %0d", occupancy, exp.occupancy));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  djrq_req_if req_ch();
  djrq_rsp_if rsp_ch();

  dedup_job_ring_queue dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  job_ring_tracker tracker;
  int unsigned sent_count = 0;
  int unsigned cycle_count = 0;
  bit calm = 0;
  bit squeeze_done = 0;
  logic [KEY_W-1:0] key_pool[KEY_POOL];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      tracker.check_answer(rsp_ch.status, rsp_ch.out_key, rsp_ch.out_payload,
                           rsp_ch.out_kind, rsp_ch.occupancy);
  end

  task send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                    input logic [PAY_W-1:0] payload, input logic kind);
    req_ch.valid <= 1'b1;
    req_ch.opcode <= op;
    req_ch.job_key <= key;
    req_ch.job_payload <= payload;
    req_ch.job_kind <= kind;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    tracker.note_request(op, key, payload, kind);
    sent_count++;
  endtask

  task pause_sender(input int unsigned cycles);
    req_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Response side: random stalls, plus one long hold-off so the block backs up.
  initial begin
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!squeeze_done && sent_count >= SQUEEZE_AFTER) begin
        rsp_ch.ready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
        squeeze_done = 1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  initial begin
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    int unsigned mode;
    int unsigned roll;
    bit no_gaps;

    tracker = new();
    req_ch.valid <= 1'b0;
    req_ch.opcode <= OP_ENQUEUE;
    req_ch.job_key <= '0;
    req_ch.job_payload <= '0;
    req_ch.job_kind <= 1'b0;
    for (int i = 0; i < KEY_POOL; i++) key_pool[i] = {$urandom, $urandom};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty-queue cases and the undefined opcode.
    send_request(OP_RELEASE, '1, '1, 1'b1);
    send_request(OP_DEQUEUE, '1, '1, 1'b1);
    send_request(OP_NOP, '1, '1, 1'b1);
    // Extreme keys, a replace, a repeated take and an enqueue hitting a taken job.
    send_request(OP_ENQUEUE, '0, '0, 1'b0);
    send_request(OP_ENQUEUE, '1, '1, 1'b1);
    send_request(OP_ENQUEUE, '1, 32'h5A5A_A5A5, 1'b0);
    send_request(OP_DEQUEUE, '0, '0, 1'b0);
    send_request(OP_DEQUEUE, '0, '0, 1'b0);
    pause_sender(3);
    send_request(OP_ENQUEUE, '0, 32'h1234_5678, 1'b1);
    // Fill to capacity, then a new key is refused while a queued one is replaced.
    for (int i = 0; i < QUEUE_DEPTH - 2; i++)
      send_request(OP_ENQUEUE, {32'hC0DE_0000 | i, $urandom}, $urandom, i[0]);
    send_request(OP_ENQUEUE, {$urandom, $urandom}, $urandom, 1'b1);
    send_request(OP_ENQUEUE, '1, '0, 1'b1);

    mode = 0;
    no_gaps = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        mode = $urandom_range(0, 2);
        no_gaps = ($urandom_range(0, 3) == 0);
      end
      if (sent_count >= CALM_AFTER) calm = 1;
      roll = $urandom_range(0, 99);
      // Modes lean toward filling, draining, or a steady mix.
      case (mode)
        0: op = (roll < 70) ? OP_ENQUEUE : (roll < 85) ? OP_DEQUEUE :
                (roll < 97) ? OP_RELEASE : OP_NOP;
        1: op = (roll < 20) ? OP_ENQUEUE : (roll < 45) ? OP_DEQUEUE :
                (roll < 97) ? OP_RELEASE : OP_NOP;
        default: op = (roll < 45) ? OP_ENQUEUE : (roll < 70) ? OP_DEQUEUE :
                      (roll < 97) ? OP_RELEASE : OP_NOP;
      endcase
      if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, KEY_POOL - 1)];
      else key = {$urandom, $urandom};
      send_request(op, key, $urandom, 1'($urandom_range(0, 1)));
      if (!calm && !no_gaps && $urandom_range(0, 2) == 0)
        pause_sender($urandom_range(1, 17));
    end
    req_ch.valid <= 1'b0;

    while (tracker.pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule

### files.f
rtl/djrq_pkg.sv
rtl/djrq_if.sv
rtl/djrq_cell.sv
rtl/dedup_job_ring_queue.sv
sim/testbench.sv
